// ===== sv/sau_pkg.sv =====
// Package: stack arithmetic unit types, codes and constants.
package sau_pkg;

	localparam int STACK_DEPTH_DEF = 1024;
	localparam int WORD_WIDTH_DEF  = 32;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_POP  = 3'd1,
		OP_PEEKT = 3'd2,
		OP_PEEKB = 3'd3,
		OP_ADD  = 3'd4,
		OP_SUB  = 3'd5,
		OP_MUL  = 3'd6,
		OP_DIV  = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_FEW     = 3'd4,
		ST_DIVZERO = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] push_value;
		logic [9:0]         position;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
		logic [10:0]        stack_depth;
	} out_item_t;

	// Back-end states
	typedef enum logic [2:0] {
		BS_IDLE,
		BS_RD1,
		BS_RD2,
		BS_EXEC,
		BS_DIV,
		BS_FIX,
		BS_WR,
		BS_OUT
	} bstate_t;

endpackage

// ===== sv/sau_front.sv =====
// Front end: accept instructions and queue them for the back end.
module sau_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sau_pkg::in_item_t in_item,
	output logic             q_valid,
	input  logic             q_ready,
	output sau_pkg::in_item_t q_item
);
	localparam int QD = sau_pkg::QUEUE_DEPTH;
	localparam int QW = $clog2(QD);

	sau_pkg::in_item_t mem_q [QD];
	logic [QW-1:0] wp_q, rp_q;
	logic [QW:0]   cnt_q;
	logic          push, pop;

	assign in_ready = (cnt_q != QW'(0) + (QW+1)'(QD)) ? 1'b1 : 1'b0;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Hold queued transactions
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QW'(QD - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QW'(QD - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end
endmodule

// ===== sv/sau_back.sv =====
// Back end: stack memory, arithmetic, iterative divider, output register.
module sau_back #(
	parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF,
	parameter int WORD_WIDTH  = sau_pkg::WORD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  sau_pkg::in_item_t q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output sau_pkg::out_item_t out_item
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = AW + 1;
	localparam int DCW = $clog2(WORD_WIDTH + 1);
	localparam int W = WORD_WIDTH;

	sau_pkg::bstate_t st_q, st_d;

	logic [W-1:0] mem [STACK_DEPTH];
	logic [W-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic          rd_en;
	logic [AW-1:0] waddr;
	logic [W-1:0]  wdata;
	logic          wr_en;

	logic [CW-1:0] cnt_q;
	logic [2:0]    op_q;
	logic [W-1:0]  pv_q, rhs_q, res_q;
	logic [9:0]    pos_q;
	logic [2:0]    stat_q;
	logic [DCW-1:0] dcnt_q;
	logic [W-1:0]  rem_q, quo_q, mb_q;
	logic          differ_q;
	logic          obusy_q;
	sau_pkg::out_item_t oreg_q;

	logic [CW-1:0] posx;
	logic [W:0]    trial;
	logic [W-1:0]  rem_sh;
	logic [W-1:0]  qadj;

	assign posx  = (CW > 10) ? CW'(pos_q) : CW'(pos_q);
	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, mb_q};
	assign qadj  = quo_q + W'(rem_q != '0);

	// Memory read and write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Next state, memory control
	always_comb begin
		st_d  = st_q;
		q_ready = 1'b0;
		rd_en = 1'b0;
		raddr = '0;
		wr_en = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = res_q;
		case (st_q)
			sau_pkg::BS_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					st_d = sau_pkg::BS_RD1;
				end
			end
			sau_pkg::BS_RD1: begin
				st_d = sau_pkg::BS_OUT;
				case (op_q)
					sau_pkg::OP_PUSH: begin
						if (cnt_q < CW'(STACK_DEPTH)) begin
							wr_en = 1'b1;
							wdata = pv_q;
						end
					end
					sau_pkg::OP_POP: begin
						if (cnt_q != '0) begin
							rd_en = 1'b1;
							raddr = AW'(cnt_q - 1'b1);
							st_d = sau_pkg::BS_EXEC;
						end
					end
					sau_pkg::OP_PEEKT: begin
						if ({1'b0, pos_q} < 11'(cnt_q) && posx < cnt_q) begin
							rd_en = 1'b1;
							raddr = AW'(cnt_q - 1'b1 - posx);
							st_d = sau_pkg::BS_EXEC;
						end
					end
					sau_pkg::OP_PEEKB: begin
						if ({1'b0, pos_q} < 11'(cnt_q) && posx < cnt_q) begin
							rd_en = 1'b1;
							raddr = AW'(posx);
							st_d = sau_pkg::BS_EXEC;
						end
					end
					default: begin
						if (cnt_q >= CW'(2)) begin
							rd_en = 1'b1;
							raddr = AW'(cnt_q - 1'b1);
							st_d = sau_pkg::BS_RD2;
						end
					end
				endcase
			end
			sau_pkg::BS_RD2: begin
				rd_en = 1'b1;
				raddr = AW'(cnt_q - CW'(2));
				st_d = sau_pkg::BS_EXEC;
			end
			sau_pkg::BS_EXEC: begin
				if (op_q == sau_pkg::OP_DIV && rhs_q != '0) begin
					st_d = sau_pkg::BS_DIV;
				end else if (op_q inside {sau_pkg::OP_ADD, sau_pkg::OP_SUB,
						sau_pkg::OP_MUL}) begin
					st_d = sau_pkg::BS_WR;
				end else begin
					st_d = sau_pkg::BS_OUT;
				end
			end
			sau_pkg::BS_DIV: begin
				if (dcnt_q == DCW'(1)) begin
					st_d = sau_pkg::BS_FIX;
				end
			end
			sau_pkg::BS_FIX: begin
				st_d = sau_pkg::BS_WR;
			end
			sau_pkg::BS_WR: begin
				wr_en = 1'b1;
				waddr = AW'(cnt_q - CW'(2));
				st_d = sau_pkg::BS_OUT;
			end
			sau_pkg::BS_OUT: begin
				if (!obusy_q || out_ready) begin
					st_d = sau_pkg::BS_IDLE;
				end
			end
			default: st_d = sau_pkg::BS_IDLE;
		endcase
	end

	// Hold state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= sau_pkg::BS_IDLE;
			cnt_q   <= '0;
			obusy_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == sau_pkg::BS_OUT && (!obusy_q || out_ready)) begin
				obusy_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				obusy_q <= 1'b0;
			end
			case (st_q)
				sau_pkg::BS_RD1: begin
					if (op_q == sau_pkg::OP_PUSH && cnt_q < CW'(STACK_DEPTH)) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (op_q == sau_pkg::OP_POP && cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				sau_pkg::BS_EXEC: begin
					if (op_q == sau_pkg::OP_DIV && rhs_q == '0) begin
						cnt_q <= cnt_q - CW'(2);
					end
				end
				sau_pkg::BS_WR: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			sau_pkg::BS_IDLE: begin
				op_q   <= q_item.op;
				pv_q   <= W'(q_item.push_value);
				pos_q  <= q_item.position;
				res_q  <= '0;
				stat_q <= sau_pkg::ST_OK;
			end
			sau_pkg::BS_RD1: begin
				case (op_q)
					sau_pkg::OP_PUSH:
						if (cnt_q >= CW'(STACK_DEPTH)) stat_q <= sau_pkg::ST_FULL;
					sau_pkg::OP_POP:
						if (cnt_q == '0) stat_q <= sau_pkg::ST_EMPTY;
					sau_pkg::OP_PEEKT, sau_pkg::OP_PEEKB:
						if (!({1'b0, pos_q} < 11'(cnt_q) && posx < cnt_q))
							stat_q <= sau_pkg::ST_RANGE;
					default:
						if (cnt_q < CW'(2)) stat_q <= sau_pkg::ST_FEW;
				endcase
			end
			sau_pkg::BS_RD2: begin
				rhs_q <= rdata_q;
			end
			sau_pkg::BS_EXEC: begin
				case (op_q)
					sau_pkg::OP_ADD: res_q <= rdata_q + rhs_q;
					sau_pkg::OP_SUB: res_q <= rdata_q - rhs_q;
					sau_pkg::OP_MUL: res_q <= W'(rdata_q * rhs_q);
					sau_pkg::OP_DIV: begin
						if (rhs_q == '0) begin
							stat_q <= sau_pkg::ST_DIVZERO;
						end
						quo_q  <= rdata_q[W-1] ? -rdata_q : rdata_q;
						mb_q   <= rhs_q[W-1] ? -rhs_q : rhs_q;
						rem_q  <= '0;
						dcnt_q <= DCW'(W);
						differ_q <= rdata_q[W-1] ^ rhs_q[W-1];
					end
					default: res_q <= rdata_q;
				endcase
			end
			sau_pkg::BS_DIV: begin
				// One restoring step per cycle
				dcnt_q <= dcnt_q - 1'b1;
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
			sau_pkg::BS_FIX: begin
				res_q <= differ_q ? -qadj : quo_q;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (st_q == sau_pkg::BS_OUT && (!obusy_q || out_ready)) begin
			oreg_q.result_value <= (stat_q == sau_pkg::ST_OK) ? 32'(res_q) : '0;
			oreg_q.status       <= stat_q;
			oreg_q.stack_depth  <= 11'(cnt_q);
		end
	end

	assign out_valid = obusy_q;
	assign out_item  = oreg_q;
endmodule

// ===== sv/stack_arithmetic_unit.sv =====
// Top level: stack arithmetic unit.
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | sau_pkg::in_item_t
//  out     | output    | out_valid/out_ready | sau_pkg::out_item_t
// Push passes states RD1 and OUT; pop and peek add EXEC; add, subtract, multiply
// also pass RD2 and WR. Divide runs the one-bit-per-cycle divider, then FIX and WR.
// The back end serves one instruction at a time through one memory port.
// Reset empties the stack at once; no memory clearing is needed.
// A two-entry queue lets input be taken while the back end or output stalls.
module stack_arithmetic_unit #(
	parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF,
	parameter int WORD_WIDTH  = sau_pkg::WORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sau_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output sau_pkg::out_item_t out_item
);
	logic              q_valid, q_ready;
	sau_pkg::in_item_t q_item;

	sau_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	sau_back #(.STACK_DEPTH(STACK_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule
